// ===== rtl/nct_pkg.sv =====
`timescale 1ns / 1ps
package nct_pkg;

   // column type codes
   localparam logic [2:0] TY_BOOL  = 3'd0;
   localparam logic [2:0] TY_INT8  = 3'd1;
   localparam logic [2:0] TY_INT16 = 3'd2;
   localparam logic [2:0] TY_INT32 = 3'd3;
   localparam logic [2:0] TY_INT64 = 3'd4;
   localparam logic [2:0] TY_F32   = 3'd5;
   localparam logic [2:0] TY_F64   = 3'd6;

   // register indexes
   localparam logic CSR_SOURCE = 1'b0;
   localparam logic CSR_TARGET = 1'b1;

   localparam logic [2:0] SOURCE_RESET = TY_INT32;
   localparam logic [2:0] TARGET_RESET = TY_INT32;

   localparam logic [63:0] F32_ONE     = 64'h0000_0000_3F80_0000;
   localparam logic [63:0] F64_ONE     = 64'h3FF0_0000_0000_0000;
   localparam logic [30:0] F32_EPS_ABS = 31'h3586_37BD;
   localparam logic [30:0] F32_INF_ABS = 31'h7F80_0000;
   localparam logic [62:0] F64_EPS_ABS = 63'h3E11_2E0B_E826_D695;
   localparam logic [62:0] F64_INF_ABS = 63'h7FF0_0000_0000_0000;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        value_null;
      logic        last_row;
   } req_type;

   typedef struct packed {
      logic [63:0] result_bits;
      logic        result_null;
      logic        result_last;
   } rsp_type;

endpackage

// ===== rtl/numeric_type_cast.sv =====
`timescale 1ns / 1ps
// numeric_type_cast: four-stage pipeline from request to result
// throughput one request per cycle while the result is not stalled; stages are decode, normalise count,
// shift, and round/pack with the output register
// a stalled result holds the last stage and every occupied stage behind it; earlier bubbles still fill
// synchronous active-high reset empties the pipeline and sets both types to int32
module numeric_type_cast (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nct_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nct_pkg::rsp_type  rsp_payload,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [2:0]        csr_wdata
);

   typedef enum logic [1:0] {OP_DONE, OP_NORM, OP_F2I, OP_D2F} op_type;

   typedef struct packed {
      op_type             op;
      logic               sign;
      logic [63:0]        data;
      logic signed [12:0] expo;
      logic [5:0]         amt;
      logic               dbl;
      logic [2:0]         tgt;
      logic               kill;
      logic               grd;
      logic               stk;
      logic               rnull;
      logic               last;
   } stage_type;

   function automatic logic fits(input logic [63:0] x, input logic [2:0] t);
      logic ok;
      case (t)
         nct_pkg::TY_INT8:  ok = (&x[63:7])  || !(|x[63:7]);
         nct_pkg::TY_INT16: ok = (&x[63:15]) || !(|x[63:15]);
         nct_pkg::TY_INT32: ok = (&x[63:31]) || !(|x[63:31]);
         default:           ok = 1'b1;
      endcase
      return ok;
   endfunction

   function automatic logic [5:0] lzc64(input logic [63:0] x);
      logic [63:0] v;
      logic [5:0]  n;
      v = x;
      n = '0;
      for (int lvl = 5; lvl >= 0; lvl--) begin
         if ((v >> (64 - (1 << lvl))) == 64'd0) begin
            n = n | 6'(1 << lvl);
            v = v << (1 << lvl);
         end
      end
      return n;
   endfunction

   logic [2:0] source_ff, target_ff;
   logic       v1_ff, v2_ff, v3_ff, v4_ff;
   logic       rdy1, rdy2, rdy3, rdy4;
   stage_type  st1_ff, st2_ff, st3_ff;
   stage_type  st1_in, st2_in, st3_in;
   nct_pkg::rsp_type out_ff, out_in;

   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall = !rdy1;
   assign rsp_valid = v4_ff;
   assign rsp_payload = out_ff;

   // stage 1: decode and unpack
   logic [63:0] v, iv, mag;
   logic [2:0]  s, t;
   always_comb begin
      v = req_payload.value_bits;
      s = source_ff;
      t = target_ff;
      case (s)
         nct_pkg::TY_INT8:  iv = {{56{v[7]}}, v[7:0]};
         nct_pkg::TY_INT16: iv = {{48{v[15]}}, v[15:0]};
         nct_pkg::TY_INT32: iv = {{32{v[31]}}, v[31:0]};
         default:           iv = v;
      endcase
      mag = iv[63] ? (64'd0 - iv) : iv;
      st1_in = '0;
      st1_in.op = OP_DONE;
      st1_in.tgt = t;
      st1_in.last = req_payload.last_row;
      if (s > nct_pkg::TY_F64 || t > nct_pkg::TY_F64 || req_payload.value_null) begin
         st1_in.rnull = 1'b1;
      end else if (s == t) begin
         st1_in.data = v;
      end else if (s == nct_pkg::TY_BOOL) begin
         if (t == nct_pkg::TY_F32) st1_in.data = v[0] ? nct_pkg::F32_ONE : 64'd0;
         else if (t == nct_pkg::TY_F64) st1_in.data = v[0] ? nct_pkg::F64_ONE : 64'd0;
         else st1_in.data = {63'd0, v[0]};
      end else if (s <= nct_pkg::TY_INT64) begin
         if (t == nct_pkg::TY_BOOL) begin
            st1_in.data = {63'd0, iv != 64'd0};
         end else if (t == nct_pkg::TY_F32 || t == nct_pkg::TY_F64) begin
            st1_in.op = OP_NORM;
            st1_in.sign = iv[63];
            st1_in.data = mag;
            st1_in.dbl = (t == nct_pkg::TY_F64);
            st1_in.expo = (t == nct_pkg::TY_F64) ? 13'sd1023 : 13'sd127;
         end else begin
            st1_in.data = iv;
            st1_in.rnull = !fits(iv, t);
         end
      end else if (s == nct_pkg::TY_F32) begin
         if (t == nct_pkg::TY_BOOL) begin
            st1_in.data = {63'd0, (v[30:0] > nct_pkg::F32_EPS_ABS)
                                  && (v[30:0] <= nct_pkg::F32_INF_ABS)};
         end else if (t == nct_pkg::TY_F64) begin
            if (v[30:23] == 8'hFF) begin
               // quiet bit set, payload moves up by 29
               st1_in.data = (v[22:0] == 23'd0) ? {v[31], 11'h7FF, 52'd0}
                                                : {v[31], 12'hFFF, v[21:0], 29'd0};
            end else if (v[30:23] == 8'd0) begin
               if (v[22:0] == 23'd0) begin
                  st1_in.data = {v[31], 63'd0};
               end else begin
                  // subnormal single becomes a normal double
                  st1_in.op = OP_NORM;
                  st1_in.sign = v[31];
                  st1_in.data = {41'd0, v[22:0]};
                  st1_in.dbl = 1'b1;
                  st1_in.expo = 13'sd874;
               end
            end else begin
               st1_in.data = {v[31], {3'd0, v[30:23]} + 11'd896, v[22:0], 29'd0};
            end
         end else begin
            st1_in.op = OP_F2I;
            st1_in.sign = v[31];
            st1_in.data = {1'b1, v[22:0], 40'd0};
            st1_in.expo = 13'({5'd0, v[30:23]}) - 13'sd127;
            st1_in.rnull = (v[30:23] == 8'hFF);
         end
      end else begin
         if (t == nct_pkg::TY_BOOL) begin
            st1_in.data = {63'd0, (v[62:0] > nct_pkg::F64_EPS_ABS)
                                  && (v[62:0] <= nct_pkg::F64_INF_ABS)};
         end else if (t == nct_pkg::TY_F32) begin
            if (v[62:52] == 11'h7FF) begin
               st1_in.data = (v[51:0] == 52'd0) ? {32'd0, v[63], 8'hFF, 23'd0}
                                                : {32'd0, v[63], 9'h1FF, v[50:29]};
            end else if (v[62:52] == 11'd0) begin
               st1_in.data = {32'd0, v[63], 31'd0};
            end else begin
               st1_in.op = OP_D2F;
               st1_in.sign = v[63];
               st1_in.data = {11'd0, 1'b1, v[51:0]};
               st1_in.expo = 13'({2'd0, v[62:52]}) - 13'sd896;
            end
         end else begin
            st1_in.op = OP_F2I;
            st1_in.sign = v[63];
            st1_in.data = {1'b1, v[51:0], 11'd0};
            st1_in.expo = 13'({2'd0, v[62:52]}) - 13'sd1023;
            st1_in.rnull = (v[62:52] == 11'h7FF);
         end
      end
   end

   // stage 2: shift amounts
   logic signed [12:0] sub_shift;
   always_comb begin
      st2_in = st1_ff;
      sub_shift = 13'sd30 - st1_ff.expo;
      case (st1_ff.op)
         OP_NORM: st2_in.amt = lzc64(st1_ff.data);
         OP_F2I: begin
            st2_in.amt = 6'd63 - st1_ff.expo[5:0];
            if (st1_ff.expo[12]) begin
               st2_in.kill = 1'b1;
            end else if (st1_ff.expo[11:6] != 6'd0) begin
               st2_in.rnull = 1'b1;
            end else if (st1_ff.expo[5:0] == 6'd63
                         && !(st1_ff.sign && st1_ff.data[62:0] == 63'd0)) begin
               // only -2^63 survives at this exponent
               st2_in.rnull = 1'b1;
            end
         end
         OP_D2F: begin
            if (!st1_ff.expo[12] && st1_ff.expo != 13'sd0) st2_in.amt = 6'd29;
            else if (sub_shift[12:6] != 7'd0) st2_in.amt = 6'd63;
            else st2_in.amt = sub_shift[5:0];
         end
         default: st2_in.amt = '0;
      endcase
   end

   // stage 3: barrel shift
   logic [63:0] lowmask, half;
   always_comb begin
      st3_in = st2_ff;
      lowmask = ~(64'hFFFF_FFFF_FFFF_FFFF << st2_ff.amt);
      half = 64'd1 << (st2_ff.amt - 6'd1);
      case (st2_ff.op)
         OP_NORM: begin
            st3_in.data = st2_ff.data << st2_ff.amt;
            st3_in.expo = st2_ff.expo + 13'sd63 - 13'($unsigned({7'd0, st2_ff.amt}));
         end
         OP_F2I: st3_in.data = st2_ff.kill ? 64'd0 : (st2_ff.data >> st2_ff.amt);
         OP_D2F: begin
            st3_in.data = st2_ff.data >> st2_ff.amt;
            st3_in.grd = |(st2_ff.data & half);
            st3_in.stk = |(st2_ff.data & lowmask & ~half);
         end
         default: st3_in.data = st2_ff.data;
      endcase
   end

   // stage 4: round, pack and range check
   logic [12:0] em1;
   logic [24:0] m25;
   logic [53:0] m54;
   logic [35:0] sum36;
   logic [63:0] sum64, ti;
   logic        up;
   always_comb begin
      em1 = st3_ff.expo - 13'sd1;
      m25 = '0;
      m54 = '0;
      sum36 = '0;
      sum64 = '0;
      up = 1'b0;
      ti = st3_ff.sign ? (64'd0 - st3_ff.data) : st3_ff.data;
      out_in.result_last = st3_ff.last;
      out_in.result_null = st3_ff.rnull;
      out_in.result_bits = st3_ff.data;
      case (st3_ff.op)
         OP_NORM: begin
            if (!st3_ff.dbl) begin
               up = st3_ff.data[39] && ((|st3_ff.data[38:0]) || st3_ff.data[40]);
               m25 = {1'b0, st3_ff.data[63:40]} + 25'(up);
               sum36 = {em1, 23'd0} + 36'(m25);
               out_in.result_bits = {32'd0, st3_ff.sign, sum36[30:0]};
            end else begin
               up = st3_ff.data[10] && ((|st3_ff.data[9:0]) || st3_ff.data[11]);
               m54 = {1'b0, st3_ff.data[63:11]} + 54'(up);
               sum64 = {em1[11:0], 52'd0} + 64'(m54);
               out_in.result_bits = {st3_ff.sign, sum64[62:0]};
            end
            if (!st3_ff.data[63]) out_in.result_bits = 64'd0;
         end
         OP_F2I: begin
            out_in.result_bits = ti;
            if (!fits(ti, st3_ff.tgt)) out_in.result_null = 1'b1;
         end
         OP_D2F: begin
            up = st3_ff.grd && (st3_ff.stk || st3_ff.data[0]);
            m25 = st3_ff.data[24:0] + 25'(up);
            sum36 = ((!st3_ff.expo[12] && st3_ff.expo != 13'sd0) ? {em1, 23'd0} : 36'd0)
                    + 36'(m25);
            if (sum36 >= 36'h0_7F80_0000) out_in.result_bits = {32'd0, st3_ff.sign, 31'h7F80_0000};
            else out_in.result_bits = {32'd0, st3_ff.sign, sum36[30:0]};
         end
         default: out_in.result_bits = st3_ff.data;
      endcase
      if (out_in.result_null) out_in.result_bits = 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= nct_pkg::SOURCE_RESET;
         target_ff <= nct_pkg::TARGET_RESET;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == nct_pkg::CSR_SOURCE) source_ff <= csr_wdata;
            else target_ff <= csr_wdata;
         end
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) st1_ff <= st1_in;
      if (rdy2) st2_ff <= st2_in;
      if (rdy3) st3_ff <= st3_in;
      if (rdy4) out_ff <= out_in;
   end

   // a null result never carries value bits
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_null |-> rsp_payload.result_bits == 64'd0)
      else $error("null result with nonzero bits");

   // requests are held back only when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff)
      else $error("stall with a free stage");

   // a result taken with nothing behind leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !rsp_stall && !v3_ff |=> !v4_ff)
      else $error("result repeated");

endmodule

// ===== bench/nct_checker.sv =====
`timescale 1ns / 1ps
module nct_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  nct_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  nct_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [2:0]       csr_wdata,
   output int               errors,
   output int               outstanding,
   output int               results_seen
);
   import nct_pkg::*;

   logic [2:0] src_type;
   logic [2:0] dst_type;
   rsp_type    cast_expected[$];

   function automatic int int_bits(logic [2:0] t);
      case (t)
         TY_INT8:  return 8;
         TY_INT16: return 16;
         TY_INT32: return 32;
         default:  return 64;
      endcase
   endfunction

   function automatic logic [63:0] sign_ext(logic [63:0] v, int w);
      case (w)
         8:       return {{56{v[7]}}, v[7:0]};
         16:      return {{48{v[15]}}, v[15:0]};
         32:      return {{32{v[31]}}, v[31:0]};
         default: return v;
      endcase
   endfunction

   function automatic int top_bit(logic [63:0] v);
      int p;
      p = 0;
      while (v > 1) begin
         v = v >> 1;
         p++;
      end
      return p;
   endfunction

   // shift right, round to nearest, ties to even
   function automatic logic [63:0] round_shift(logic [63:0] v, int s);
      logic [63:0] q, r, h;
      q = v >> s;
      r = v & ((64'd1 << s) - 1);
      h = 64'd1 << (s - 1);
      if (r > h || (r == h && q[0])) q++;
      return q;
   endfunction

   function automatic logic [63:0] int_to_ieee(logic [63:0] v, int m, int e);
      logic        sgn;
      logic [63:0] mag, mant, bias;
      int          p;
      sgn = v[63];
      mag = sgn ? -v : v;
      if (mag == 0) return 64'd0;
      bias = (64'd1 << (e - 1)) - 1;
      p = top_bit(mag);
      if (p <= m) begin
         mant = mag << (m - p);
      end else begin
         mant = round_shift(mag, p - m);
         if ((mant >> (m + 1)) != 0) begin
            mant = mant >> 1;
            p++;
         end
      end
      return (64'(sgn) << (m + e)) | ((64'(p) + bias) << m) | (mant & ((64'd1 << m) - 1));
   endfunction

   function automatic logic [63:0] widen_f32(logic [31:0] fb);
      logic [63:0] sgn, frac;
      int          p;
      sgn  = 64'(fb[31]) << 63;
      frac = 64'(fb[22:0]);
      if (fb[30:23] == 8'hFF) begin
         if (frac == 0) return sgn | 64'h7FF0_0000_0000_0000;
         return sgn | 64'h7FF8_0000_0000_0000 | (frac << 29);
      end
      if (fb[30:23] == 0) begin
         if (frac == 0) return sgn;
         p = top_bit(frac);
         return sgn | (64'(p + 1023 - 149) << 52) | ((frac << (52 - p)) & 64'hF_FFFF_FFFF_FFFF);
      end
      return sgn | (64'(int'(fb[30:23]) - 127 + 1023) << 52) | (frac << 29);
   endfunction

   function automatic logic [63:0] narrow_f64(logic [63:0] db);
      logic [63:0] sgn, frac, sig, mant;
      int          ex, fe;
      sgn  = 64'(db[63]) << 31;
      ex   = int'(db[62:52]);
      frac = db & 64'hF_FFFF_FFFF_FFFF;
      if (ex == 'h7FF) begin
         if (frac == 0) return sgn | 64'h7F80_0000;
         return sgn | 64'h7FC0_0000 | (frac >> 29);
      end
      if (ex == 0) return sgn;
      sig = frac | (64'd1 << 52);
      fe  = ex - 1023 + 127;
      if (fe >= 1) begin
         mant = round_shift(sig, 29);
         if ((mant >> 24) != 0) begin
            mant = mant >> 1;
            fe++;
         end
         if (fe >= 255) return sgn | 64'h7F80_0000;
         return sgn | (64'(fe) << 23) | (mant & 64'h7F_FFFF);
      end
      if (30 - fe >= 55) return sgn;
      return sgn | round_shift(sig, 30 - fe);
   endfunction

   // truncate a double toward zero; fits is low when NaN or out of range
   function automatic logic [63:0] trunc_f64(logic [63:0] db, int w, output logic fits);
      logic [63:0] sig, mag, val;
      int          ex, u;
      ex  = int'(db[62:52]);
      sig = (db & 64'hF_FFFF_FFFF_FFFF) | (64'd1 << 52);
      fits = 1'b0;
      if (ex >= 1086) begin
         // only -2^63 itself survives
         if (!(db == 64'hC3E0_0000_0000_0000)) return 64'd0;
         val = 64'h8000_0000_0000_0000;
      end else if (ex < 1023) begin
         val = 64'd0;
      end else begin
         u   = ex - 1023;
         mag = (u >= 52) ? (sig << (u - 52)) : (sig >> (52 - u));
         val = db[63] ? -mag : mag;
      end
      if (sign_ext(val, w) != val) return 64'd0;
      fits = 1'b1;
      return val;
   endfunction

   function automatic rsp_type predict_cast(req_type rq, logic [2:0] s, logic [2:0] t);
      rsp_type     r;
      logic [63:0] v, iv;
      logic        fits;
      v = rq.value_bits;
      r.result_bits = 64'd0;
      r.result_null = 1'b0;
      r.result_last = rq.last_row;
      fits = 1'b1;
      if (s > TY_F64 || t > TY_F64 || rq.value_null) begin
         r.result_null = 1'b1;
      end else if (s == t) begin
         r.result_bits = v;
      end else if (s == TY_BOOL) begin
         if (t == TY_F32) r.result_bits = v[0] ? 64'h3F80_0000 : 64'd0;
         else if (t == TY_F64) r.result_bits = v[0] ? 64'h3FF0_0000_0000_0000 : 64'd0;
         else r.result_bits = 64'(v[0]);
      end else if (s <= TY_INT64) begin
         iv = sign_ext(v, int_bits(s));
         if (t == TY_BOOL) r.result_bits = 64'(iv != 0);
         else if (t == TY_F32) r.result_bits = int_to_ieee(iv, 23, 8);
         else if (t == TY_F64) r.result_bits = int_to_ieee(iv, 52, 11);
         else if (sign_ext(iv, int_bits(t)) != iv) r.result_null = 1'b1;
         else r.result_bits = iv;
      end else if (s == TY_F32) begin
         if (t == TY_BOOL)
            r.result_bits = 64'(v[30:0] > 31'h3586_37BD && v[30:0] <= 31'h7F80_0000);
         else if (t == TY_F64) r.result_bits = widen_f32(v[31:0]);
         else r.result_bits = trunc_f64(widen_f32(v[31:0]), int_bits(t), fits);
      end else begin
         if (t == TY_BOOL)
            r.result_bits = 64'(v[62:0] > 63'h3E11_2E0B_E826_D695
                                && v[62:0] <= 63'h7FF0_0000_0000_0000);
         else if (t == TY_F32) r.result_bits = narrow_f64(v);
         else r.result_bits = trunc_f64(v, int_bits(t), fits);
      end
      if (!fits) r.result_null = 1'b1;
      if (r.result_null) r.result_bits = 64'd0;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         src_type <= SOURCE_RESET;
         dst_type <= TARGET_RESET;
         cast_expected.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_SOURCE) src_type <= csr_wdata;
            else dst_type <= csr_wdata;
         end
         if (req_valid && !req_stall)
            cast_expected.push_back(predict_cast(req_payload, src_type, dst_type));
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (cast_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected result %h", $time, rsp_payload);
            end else begin
               exp_r = cast_expected.pop_front();
               if (rsp_payload.result_bits !== exp_r.result_bits
                   || rsp_payload.result_null !== exp_r.result_null
                   || rsp_payload.result_last !== exp_r.result_last) begin
                  errors++;
                  $display("%0t: mismatch expected bits=%h null=%b last=%b actual bits=%h null=%b last=%b",
                           $time, exp_r.result_bits, exp_r.result_null, exp_r.result_last,
                           rsp_payload.result_bits, rsp_payload.result_null,
                           rsp_payload.result_last);
               end
            end
         end
      end
      outstanding <= cast_expected.size();
   end

   initial begin
      errors = 0;
      outstanding = 0;
      results_seen = 0;
   end

endmodule

// ===== bench/tb_numeric_type_cast.sv =====
`timescale 1ns / 1ps
module tb_numeric_type_cast;
   import nct_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_payload;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_payload;
   logic       csr_we;
   logic       csr_index;
   logic [2:0] csr_wdata;
   int         errors;
   int         outstanding;
   int         results_seen;
   logic       calm;

   numeric_type_cast dut (.*);

   nct_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // boundary or random value for a source type; low cat values walk the corners
   function automatic logic [63:0] pick_value(logic [2:0] s, int cat);
      logic [63:0] v;
      int          k;
      k = 8 << $urandom_range(0, 3);
      case (cat)
         0: v = 64'd0;
         1: v = 64'hFFFF_FFFF_FFFF_FFFF;
         2: v = 64'd1;
         3: v = 64'h8000_0000_0000_0000;
         4: v = 64'h7FFF_FFFF_FFFF_FFFF;
         5: v = (64'd1 << (k - 1)) - 1;
         6: v = -(64'd1 << (k - 1));
         7: v = 64'd1 << (k - 1);
         8: v = -(64'd1 << (k - 1)) - 1;
         9: v = rand64();
         10: v = 64'(($urandom & 32'h1FF_FFFF) | 1) << $urandom_range(0, 38);
         11: v = ((rand64() & 64'h3F_FFFF_FFFF_FFFF) | 1) << $urandom_range(0, 9);
         default: begin
            if (s == TY_F32) begin
               v = {rand64() & 64'hFFFF_FFFF_0000_0000} | 32'($urandom);
               case ($urandom_range(0, 5))
                  0: v[30:23] = 8'(127 + $urandom_range(0, 64));
                  1: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  2: v[30:0]  = 31'h3586_37BC + $urandom_range(0, 2);
                  3: v[30:23] = 8'(100 + $urandom_range(0, 30));
                  default: ;
               endcase
            end else if (s == TY_F64) begin
               v = rand64();
               case ($urandom_range(0, 7))
                  0: v[62:52] = 11'(1023 + $urandom_range(0, 66));
                  1: v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
                  2: v[62:0]  = 63'h3E11_2E0B_E826_D694 + $urandom_range(0, 2);
                  3: v[62:52] = 11'(1023 - 155 + $urandom_range(0, 32));
                  4: begin
                     v[62:52] = 11'(1023 + 126 + $urandom_range(0, 2));
                     v[51:0]  = ~52'd0 - $urandom_range(0, 3);
                  end
                  5: v[62:52] = 11'(1023 - $urandom_range(0, 40));
                  default: ;
               endcase
            end else if (s == TY_BOOL || $urandom_range(0, 2) == 0) begin
               v = rand64();
            end else begin
               v = 64'($signed($urandom_range(0, 400)) - 200);
               if ($urandom_range(0, 1)) v = v + (64'd1 << (k - 1));
            end
         end
      endcase
      return v;
   endfunction

   task automatic send_cast(logic [63:0] v);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{value_bits: v,
                       value_null: ($urandom_range(0, 7) == 0),
                       last_row: ($urandom_range(0, 3) == 0)};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic set_types(logic [2:0] s, logic [2:0] t);
      req_valid <= 1'b0;
      // let the count catch up with the last accepted request
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SOURCE;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_TARGET;
      csr_wdata <= t;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // result side stall
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         n = calm ? 0 : $urandom_range(0, 10);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      int total;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = CSR_SOURCE;
      csr_wdata = '0;
      calm = 1'b0;
      total = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset types first, then every other pair including the unused code
      for (int s = 0; s < 8; s++) begin
         for (int t = 0; t < 8; t++) begin
            if (!(s == 0 && t == 0)) set_types(3'(s), 3'(t));
            for (int i = 0; i < 27; i++) begin
               if ($urandom_range(0, 15) == 0) calm = ~calm;
               send_cast(pick_value(3'(s), (i < 12) ? i : 12 + $urandom_range(0, 3)));
               total++;
            end
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d requests over the reset types and 63 other type pairs, %0d results checked",
               total, results_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/nct_pkg.sv
rtl/numeric_type_cast.sv
bench/nct_checker.sv
bench/tb_numeric_type_cast.sv
